// ===== rtl/assert_macros.svh =====
// Shared assertion macros. Each one samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bygcc_pkg.sv =====
package bygcc_pkg;

  typedef enum logic [1:0] {
    MODE_BGR2YUV  = 2'd0,
    MODE_YUV2BGR  = 2'd1,
    MODE_BGR2GRAY = 2'd2
  } mode_t;

  localparam int PIX_W  = 8;
  localparam int Q_BITS = 14;
  localparam int YQ_W   = 23;                    // unsigned Q14 luma
  localparam int MX_W   = 27;                    // signed Q14 inverse-matrix sums
  localparam int DIF_W  = 24;                    // signed Q14 B-Y / R-Y
  localparam int CHR_W  = 37;                    // signed Q28 scaled chroma
  localparam int RQ_W   = MX_W - Q_BITS;         // rounded Q14 value
  localparam int RC_W   = CHR_W - 2 * Q_BITS;    // rounded Q28 value
  localparam int CL_W   = 14;                    // clamp input width

  localparam logic [YQ_W-1:0] YQ_MAX = YQ_W'(255 * 16384);

  // Q14 coefficients, round to nearest
  localparam logic        [10:0] K_YB = 11'd1868;
  localparam logic        [13:0] K_YG = 14'd9617;
  localparam logic        [12:0] K_YR = 13'd4899;
  localparam logic signed [14:0] K_U  = 15'sd8061;
  localparam logic signed [14:0] K_V  = 15'sd14369;
  localparam logic signed [17:0] K_BU = 18'sd33292;
  localparam logic signed [14:0] K_GU = 15'sd6455;
  localparam logic signed [14:0] K_GV = 15'sd9519;
  localparam logic signed [16:0] K_RV = 17'sd18678;

  localparam logic signed [CL_W-1:0] CHR_OFS  = CL_W'(128);
  localparam logic signed [CL_W-1:0] BYTE_MAX = CL_W'(255);

  typedef struct packed {
    logic [PIX_W-1:0] third;
    logic [PIX_W-1:0] second;
    logic [PIX_W-1:0] first;
  } pixel_t;

  // stage 1: constant products
  typedef struct packed {
    mode_t              mode;
    logic [PIX_W-1:0]   a;
    logic [PIX_W-1:0]   c;
    logic [18:0]        py_b;
    logic [21:0]        py_g;
    logic [20:0]        py_r;
    logic signed [25:0] pbu;
    logic signed [22:0] pgu;
    logic signed [22:0] pgv;
    logic signed [24:0] prv;
  } prod_t;

  // stage 2: sums
  typedef struct packed {
    mode_t                  mode;
    logic [PIX_W-1:0]       a;
    logic [PIX_W-1:0]       c;
    logic [YQ_W-1:0]        yq;
    logic signed [MX_W-1:0] bq;
    logic signed [MX_W-1:0] gq;
    logic signed [MX_W-1:0] rq;
  } sum_t;

  // stage 3: color differences
  typedef struct packed {
    mode_t                   mode;
    logic [YQ_W-1:0]         yq;
    logic signed [DIF_W-1:0] du;
    logic signed [DIF_W-1:0] dv;
    logic signed [MX_W-1:0]  bq;
    logic signed [MX_W-1:0]  gq;
    logic signed [MX_W-1:0]  rq;
  } diff_t;

  // stage 4: scaled chroma
  typedef struct packed {
    mode_t                   mode;
    logic [YQ_W-1:0]         yq;
    logic signed [CHR_W-1:0] mu;
    logic signed [CHR_W-1:0] mv;
    logic signed [MX_W-1:0]  bq;
    logic signed [MX_W-1:0]  gq;
    logic signed [MX_W-1:0]  rq;
  } chroma_t;

  // Round Q14 to integer, ties away from zero: (v + half - neg) >>> 14
  function automatic logic signed [RQ_W-1:0] round_q14(input logic signed [MX_W-1:0] v);
    logic signed [MX_W:0] s;
    s = (MX_W+1)'(v) + (MX_W+1)'(1 << (Q_BITS - 1)) - (MX_W+1)'(v[MX_W-1]);
    return RQ_W'(s >>> Q_BITS);
  endfunction

  // Round Q28 to integer, ties away from zero
  function automatic logic signed [RC_W-1:0] round_q28(input logic signed [CHR_W-1:0] v);
    logic signed [CHR_W:0] s;
    s = (CHR_W+1)'(v) + (CHR_W+1)'(64'd1 << (2 * Q_BITS - 1)) - (CHR_W+1)'(v[CHR_W-1]);
    return RC_W'(s >>> (2 * Q_BITS));
  endfunction

  function automatic logic [PIX_W-1:0] clamp_byte(input logic signed [CL_W-1:0] v);
    logic [PIX_W-1:0] r;
    if (v[CL_W-1]) begin
      r = '0;
    end else if (v > BYTE_MAX) begin
      r = '1;
    end else begin
      r = v[PIX_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/bygcc_matrix.sv =====
`include "assert_macros.svh"

module bygcc_matrix (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  bygcc_pkg::pixel_t  pix,
  input  bygcc_pkg::mode_t   mode,
  output logic               out_valid,
  output bygcc_pkg::sum_t    sum
);

  logic                  v1;
  bygcc_pkg::prod_t      p1;
  bygcc_pkg::prod_t      p1_next;
  bygcc_pkg::sum_t       sum_next;
  logic signed [7:0]     du;
  logic signed [7:0]     dv;
  logic signed [bygcc_pkg::MX_W-1:0] aq;

  // stage 1: all constant products, both directions
  always_comb begin
    du = $signed({~pix.second[7], pix.second[6:0]});   // U - 128
    dv = $signed({~pix.third[7], pix.third[6:0]});     // V - 128
    p1_next.mode = mode;
    p1_next.a    = pix.first;
    p1_next.c    = pix.third;
    p1_next.py_b = 19'(pix.first) * 19'(bygcc_pkg::K_YB);
    p1_next.py_g = 22'(pix.second) * 22'(bygcc_pkg::K_YG);
    p1_next.py_r = 21'(pix.third) * 21'(bygcc_pkg::K_YR);
    p1_next.pbu  = 26'(du) * 26'(bygcc_pkg::K_BU);
    p1_next.pgu  = 23'(du) * 23'(bygcc_pkg::K_GU);
    p1_next.pgv  = 23'(dv) * 23'(bygcc_pkg::K_GV);
    p1_next.prv  = 25'(dv) * 25'(bygcc_pkg::K_RV);
  end

  // stage 2: luma sum and inverse-matrix sums
  always_comb begin
    aq = $signed(bygcc_pkg::MX_W'({p1.a, {bygcc_pkg::Q_BITS{1'b0}}}));
    sum_next.mode = p1.mode;
    sum_next.a    = p1.a;
    sum_next.c    = p1.c;
    sum_next.yq   = bygcc_pkg::YQ_W'(p1.py_b) + bygcc_pkg::YQ_W'(p1.py_g)
                  + bygcc_pkg::YQ_W'(p1.py_r);
    sum_next.bq   = aq + bygcc_pkg::MX_W'(p1.pbu);
    sum_next.gq   = aq - bygcc_pkg::MX_W'(p1.pgu) - bygcc_pkg::MX_W'(p1.pgv);
    sum_next.rq   = aq + bygcc_pkg::MX_W'(p1.prv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1  <= p1_next;
      sum <= sum_next;
    end
  end

  `ASSERT_CLK(a_yq_range, !out_valid || sum.yq <= bygcc_pkg::YQ_MAX, "luma sum out of range")

endmodule

// ===== rtl/bygcc_chroma.sv =====
`include "assert_macros.svh"

module bygcc_chroma (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  bygcc_pkg::sum_t    sum,
  output logic               out_valid,
  output bygcc_pkg::chroma_t chr
);

  logic                  v3;
  bygcc_pkg::diff_t      d3;
  bygcc_pkg::diff_t      d3_next;
  bygcc_pkg::chroma_t    chr_next;

  // stage 3: B - Y and R - Y in Q14
  always_comb begin
    d3_next.mode = sum.mode;
    d3_next.yq   = sum.yq;
    d3_next.du   = $signed(bygcc_pkg::DIF_W'({sum.a, {bygcc_pkg::Q_BITS{1'b0}}}))
                 - $signed(bygcc_pkg::DIF_W'(sum.yq));
    d3_next.dv   = $signed(bygcc_pkg::DIF_W'({sum.c, {bygcc_pkg::Q_BITS{1'b0}}}))
                 - $signed(bygcc_pkg::DIF_W'(sum.yq));
    d3_next.bq   = sum.bq;
    d3_next.gq   = sum.gq;
    d3_next.rq   = sum.rq;
  end

  // stage 4: scale differences, result in Q28
  always_comb begin
    chr_next.mode = d3.mode;
    chr_next.yq   = d3.yq;
    chr_next.mu   = bygcc_pkg::CHR_W'(d3.du) * bygcc_pkg::CHR_W'(bygcc_pkg::K_U);
    chr_next.mv   = bygcc_pkg::CHR_W'(d3.dv) * bygcc_pkg::CHR_W'(bygcc_pkg::K_V);
    chr_next.bq   = d3.bq;
    chr_next.gq   = d3.gq;
    chr_next.rq   = d3.rq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v3        <= in_valid;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d3  <= d3_next;
      chr <= chr_next;
    end
  end

  `ASSERT_NEXT(a_chroma_hold, !adv, $stable(chr) && $stable(out_valid), "stage moved while held")

endmodule

// ===== rtl/bygcc_round.sv =====
`include "assert_macros.svh"

module bygcc_round (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  bygcc_pkg::chroma_t chr,
  output logic               out_valid,
  output bygcc_pkg::pixel_t  pix
);

  bygcc_pkg::pixel_t                  pix_next;
  logic signed [bygcc_pkg::RQ_W-1:0]  y_r;
  logic signed [bygcc_pkg::RQ_W-1:0]  b_r;
  logic signed [bygcc_pkg::RQ_W-1:0]  g_r;
  logic signed [bygcc_pkg::RQ_W-1:0]  r_r;
  logic signed [bygcc_pkg::RC_W-1:0]  u_r;
  logic signed [bygcc_pkg::RC_W-1:0]  v_r;
  logic signed [bygcc_pkg::CL_W-1:0]  u_o;
  logic signed [bygcc_pkg::CL_W-1:0]  v_o;
  logic                               gray_in;

  // stage 5: round, offset, clamp, select by mode
  always_comb begin
    y_r = bygcc_pkg::round_q14($signed(bygcc_pkg::MX_W'(chr.yq)));
    b_r = bygcc_pkg::round_q14(chr.bq);
    g_r = bygcc_pkg::round_q14(chr.gq);
    r_r = bygcc_pkg::round_q14(chr.rq);
    u_r = bygcc_pkg::round_q28(chr.mu);
    v_r = bygcc_pkg::round_q28(chr.mv);
    u_o = bygcc_pkg::CL_W'(u_r) + bygcc_pkg::CHR_OFS;
    v_o = bygcc_pkg::CL_W'(v_r) + bygcc_pkg::CHR_OFS;
    pix_next = '0;
    case (chr.mode)
      bygcc_pkg::MODE_BGR2YUV: begin
        pix_next.first  = bygcc_pkg::clamp_byte(bygcc_pkg::CL_W'(y_r));
        pix_next.second = bygcc_pkg::clamp_byte(u_o);
        pix_next.third  = bygcc_pkg::clamp_byte(v_o);
      end
      bygcc_pkg::MODE_YUV2BGR: begin
        pix_next.first  = bygcc_pkg::clamp_byte(bygcc_pkg::CL_W'(b_r));
        pix_next.second = bygcc_pkg::clamp_byte(bygcc_pkg::CL_W'(g_r));
        pix_next.third  = bygcc_pkg::clamp_byte(bygcc_pkg::CL_W'(r_r));
      end
      bygcc_pkg::MODE_BGR2GRAY: begin
        pix_next.first  = bygcc_pkg::clamp_byte(bygcc_pkg::CL_W'(y_r));
      end
      default: begin
        pix_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix <= pix_next;
    end
  end

  assign gray_in = adv && in_valid && chr.mode == bygcc_pkg::MODE_BGR2GRAY;

  `ASSERT_NEXT(a_gray_zero, gray_in, {pix.third, pix.second} == '0, "gray chroma not zero")

endmodule

// ===== rtl/bgr_yuv_gray_color_convert.sv =====
// Channel   Dir  Width  Contents
// s_axis    in   24     pixel in: in_first [7:0], in_second [15:8], in_third [23:16]
// m_axis    out  24     pixel out: out_first [7:0], out_second [15:8], out_third [23:16]
// cfg       in   2      conversion_mode write (cfg_wr_en, cfg_wr_data)
//
// One pixel per cycle sustained while m_axis does not stall. The five register stages
// are products, sums, differences, chroma multiply and round/clamp.
// rst is synchronous and active high; it empties the pipeline, sets mode 0 and holds
// s_axis_tready low. A stall at m_axis freezes every stage at once and drops
// s_axis_tready in the same cycle, so nothing is lost or repeated; bubbles stay.
`include "assert_macros.svh"

module bgr_yuv_gray_color_convert (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // in_first, in_second, in_third
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_first, out_second, out_third
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data
);

  bygcc_pkg::mode_t   mode;
  logic               adv;
  logic               out_stall;
  logic               v2;
  logic               v4;
  bygcc_pkg::sum_t    sum;
  bygcc_pkg::chroma_t chr;
  bygcc_pkg::pixel_t  pix_out;

  // Mode register; the user must write it only while the pipeline is empty (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= bygcc_pkg::MODE_BGR2YUV;
    end else if (cfg_wr_en) begin
      mode <= bygcc_pkg::mode_t'(cfg_wr_data);
    end
  end

  // Advance the whole pipe when the output slot is empty or being taken.
  assign out_stall     = m_axis_tvalid && !m_axis_tready;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv && !rst;

  // Stages 1 and 2: constant products, luma and inverse-matrix sums.
  bygcc_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s_axis_tvalid),
    .pix       (bygcc_pkg::pixel_t'(s_axis_tdata)),
    .mode      (mode),
    .out_valid (v2),
    .sum       (sum)
  );

  // Stages 3 and 4: color differences and chroma scaling.
  bygcc_chroma u_chroma (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (v2),
    .sum       (sum),
    .out_valid (v4),
    .chr       (chr)
  );

  // Stage 5: round, clamp and select; this is the output register.
  bygcc_round u_round (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (v4),
    .chr       (chr),
    .out_valid (m_axis_tvalid),
    .pix       (pix_out)
  );

  assign m_axis_tdata = pix_out;

  `ASSERT_IMPLY(a_stall_blocks, out_stall, !s_axis_tready, "input taken during output stall")
  `ASSERT_NEXT(a_out_from_pipe, adv && !v4, !m_axis_tvalid, "output valid without a pixel")

endmodule
